// ----- sv/ordered_value_list_core_assert.svh -----
// Assertion macros for the ordered value list core.
// OVL_ASSERT_IMPL: same-cycle implication, OVL_ASSERT_NEXT: next-cycle implication.
`ifndef ORDERED_VALUE_LIST_CORE_ASSERT_SVH
`define ORDERED_VALUE_LIST_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define OVL_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ordered_value_list_core: assertion failed");

`define OVL_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ordered_value_list_core: assertion failed");

`else

`define OVL_ASSERT_IMPL(lbl, ck, rn, ante, cons)

`define OVL_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- sv/olist_pkg.sv -----
`timescale 1ns / 1ps
package olist_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PACK
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;   // capture match flags against the key
    logic write;  // append the key at the tail cell
    logic pack;   // one compaction step
  } cell_ctl_t;

endpackage

// ----- sv/olist_cell.sv -----
`timescale 1ns / 1ps
module olist_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                               clk,
  input  olist_pkg::cell_ctl_t               ctl,
  input  logic [olist_pkg::VALUE_W-1:0]      key,
  input  logic [CNT_W-1:0]                   count,
  input  logic [olist_pkg::VALUE_W-1:0]      nb_value,
  input  logic                               nb_hole,
  input  logic                               nb_occ,
  input  logic                               left_take,
  output logic [olist_pkg::VALUE_W-1:0]      value_o,
  output logic                               hole_o,
  output logic                               occ_o,
  output logic                               take_o,
  output logic                               pend_o,
  output logic                               top_o
);
  import olist_pkg::*;

  logic [VALUE_W-1:0] value_r;
  logic               hole_r;
  logic               occ;
  logic               wr_hit;

  assign occ    = count > CNT_W'(IDX);
  assign wr_hit = ctl.write && (count == CNT_W'(IDX));
  // Pull the right neighbor's entry into this hole.
  assign take_o = ctl.pack && hole_r && occ && !nb_hole && nb_occ;
  assign pend_o = hole_r && occ;
  assign top_o  = hole_r && (count == CNT_W'(IDX + 1));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hole_r <= occ && (value_r == key);
    end else if (take_o) begin
      hole_r <= 1'b0;
    end else if (left_take) begin
      hole_r <= 1'b1;
    end
    if (wr_hit) begin
      value_r <= key;
    end else if (take_o) begin
      value_r <= nb_value;
    end
  end

  assign value_o = value_r;
  assign hole_o  = hole_r;
  assign occ_o   = occ;

endmodule

// ----- sv/ordered_value_list_core.sv -----
`timescale 1ns / 1ps
// Ordered value list: up to CAPACITY 32-bit values kept in insertion order.
// Input channel: in_data (cmd, value) transfers at a clock edge where start
// is high and busy is low. Commands: append, search, delete all matches, clear.
// Result channel: out_data (found, status, count) is shown for exactly one
// cycle with out_strobe high; the receiver cannot stall, so each result is
// taken in the cycle it appears. One result per command.
// Path from the accepting edge to the strobe:
//   append, clear: the result register alone; the next command may start at once.
//   search: match capture in every cell, then the found reduction.
//   delete: capture, then the result when nothing matches; otherwise each compaction step
//   moves every hole that has an entry on its right one cell toward the tail
//   and drops a hole sitting at the tail. The delete reports once no hole is
//   left among the entries, with busy high until then. The rate is
//   set by this neighbor-to-neighbor hole movement along the cell row.
// busy is high while a search or delete is in flight.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; stored values are not cleared, entries beyond the count are never
// read.
`include "ordered_value_list_core_assert.svh"
module ordered_value_list_core #(
  parameter int CAPACITY = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  olist_pkg::in_item_t   in_data,
  output logic                  out_strobe,
  output olist_pkg::out_item_t  out_data
);
  import olist_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               found_r, found_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_item_t          out_data_r, out_data_nxt;
  cell_ctl_t          ctl;
  logic               emit_found;
  logic               emit_status;
  logic [CNT_W+4:0]   cnt_ext;

  logic [VALUE_W-1:0] cell_val  [CAPACITY];
  logic [CAPACITY-1:0] cell_hole;
  logic [CAPACITY-1:0] cell_occ;
  logic [CAPACITY-1:0] cell_take;
  logic [CAPACITY-1:0] cell_pend;
  logic [CAPACITY-1:0] cell_top;
  logic                any_pend;
  logic                top_hole;
  logic                accept;

  // Row of cells; each reads its right neighbor's value and flags and its left neighbor's take flag.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] nb_value;
    logic               nb_hole;
    logic               nb_occ;
    logic               left_take;

    if (i == CAPACITY - 1) begin : g_last
      assign nb_value = '0;
      assign nb_hole  = 1'b1;
      assign nb_occ   = 1'b0;
    end else begin : g_mid
      assign nb_value = cell_val[i+1];
      assign nb_hole  = cell_hole[i+1];
      assign nb_occ   = cell_occ[i+1];
    end

    if (i == 0) begin : g_first
      assign left_take = 1'b0;
    end else begin : g_rest
      assign left_take = cell_take[i-1];
    end

    olist_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key       (in_data.value),
      .count     (count_r),
      .nb_value  (nb_value),
      .nb_hole   (nb_hole),
      .nb_occ    (nb_occ),
      .left_take (left_take),
      .value_o   (cell_val[i]),
      .hole_o    (cell_hole[i]),
      .occ_o     (cell_occ[i]),
      .take_o    (cell_take[i]),
      .pend_o    (cell_pend[i]),
      .top_o     (cell_top[i])
    );
  end

  assign any_pend = |cell_pend;
  assign top_hole = |cell_top;
  assign accept   = start && (state_r == S_IDLE);
  assign busy     = (state_r != S_IDLE);

  // Count field carries the low bits of the entry count.
  assign cnt_ext = {5'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      found_r      <= found_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    out_strobe_nxt = 1'b0;
    ctl            = '0;
    emit_found     = 1'b0;
    emit_status    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.cmd)
            CMD_APPEND: begin
              out_strobe_nxt = 1'b1;
              if (count_r >= CNT_W'(CAPACITY)) begin
                emit_status = 1'b1;
              end else begin
                ctl.write = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_SEARCH: begin
              ctl.load  = 1'b1;
              state_nxt = S_SCAN;
            end
            CMD_DELETE: begin
              ctl.load  = 1'b1;
              found_nxt = 1'b0;
              state_nxt = S_PACK;
            end
            CMD_CLEAR: begin
              count_nxt      = '0;
              out_strobe_nxt = 1'b1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Reduce the captured match flags and report.
        emit_found     = any_pend;
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_PACK: begin
        if (any_pend) begin
          // Advance holes toward the tail; drop the one at the tail.
          ctl.pack  = 1'b1;
          found_nxt = 1'b1;
          if (top_hole) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end else begin
          emit_found     = found_r;
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_data_nxt.found  = emit_found;
    out_data_nxt.status = emit_status;
    out_data_nxt.count  = cnt_ext[COUNT_W-1:0];
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `OVL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `OVL_ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_strobe, state_r == S_IDLE)
  `OVL_ASSERT_NEXT(a_append_grows, clk, rst_n,
                   accept && in_data.cmd == CMD_APPEND && count_r < CNT_W'(CAPACITY),
                   count_r == $past(count_r) + CNT_W'(1))
  `OVL_ASSERT_NEXT(a_pack_shrinks, clk, rst_n, state_r == S_PACK,
                   count_r <= $past(count_r))

endmodule

// ----- tb/ordered_value_list_core_checker.sv -----
`timescale 1ns / 1ps
module ordered_value_list_core_checker #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  olist_pkg::in_item_t  in_data,
  input  logic                 out_strobe,
  input  olist_pkg::out_item_t out_data,
  output int                   mismatch_total,
  output int                   results_pending
);
  import olist_pkg::*;

  logic [VALUE_W-1:0] list_mem [CAPACITY];
  int                 list_len;
  out_item_t          expected_q[$];

  // Apply one command to the shadow list and return the result it produces.
  function automatic out_item_t apply_cmd(in_item_t item);
    out_item_t res;
    int        kept;
    res = '0;
    case (item.cmd)
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = 1'b1;
        end else begin
          list_mem[list_len] = item.value;
          list_len++;
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < list_len; i++)
          if (list_mem[i] == item.value) res.found = 1'b1;
      end
      CMD_DELETE: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == item.value) begin
            res.found = 1'b1;
          end else begin
            list_mem[kept] = list_mem[i];
            kept++;
          end
        end
        list_len = kept;
      end
      default: begin
        list_len = 0;
      end
    endcase
    res.count = COUNT_W'(list_len);
    return res;
  endfunction

  task automatic log_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_total++;
    if (mismatch_total <= 10)
      $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Compare the strobed result first: it belongs to an earlier transfer than
  // any command taken at the same edge.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          log_mismatch("result with none pending (count)", 0, out_data.count);
        end else begin
          want = expected_q.pop_front();
          if (out_data.found !== want.found)
            log_mismatch("found", want.found, out_data.found);
          if (out_data.status !== want.status)
            log_mismatch("status", want.status, out_data.status);
          if (out_data.count !== want.count)
            log_mismatch("count", want.count, out_data.count);
        end
      end
      if (start && !busy)
        expected_q.push_back(apply_cmd(in_data));
    end
    results_pending = expected_q.size();
  end

endmodule

// ----- tb/ordered_value_list_core_tb.sv -----
`timescale 1ns / 1ps
module ordered_value_list_core_tb;
  import olist_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int RAND_ITEMS  = 1000;
  // Longest quiet stretch of a correct run is a sender gap plus a full-list
  // delete; allow many times that.
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 8;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_strobe;
  out_item_t out_data;

  int          mismatch_total;
  int          results_pending;
  int unsigned xfer_count;
  int          idle_cycles;
  bit          pace_on;
  logic [VALUE_W-1:0] value_pool [6];

  ordered_value_list_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  ordered_value_list_core_checker #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_strobe     (out_strobe),
    .out_data       (out_data),
    .mismatch_total (mismatch_total),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Count command transfers so the driver can see, at the falling edge, that
  // the item it holds has been taken.
  always @(posedge clk) begin
    if (rst_n && start && !busy) xfer_count <= xfer_count + 1;
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[ordered_value_list_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one command after an optional gap and hold it until transferred.
  // Entered and left at a falling edge.
  task automatic drive_cmd(cmd_t c, logic [VALUE_W-1:0] v);
    int unsigned seen;
    int          gap;
    in_item_t    junk;
    gap  = pace_on ? $urandom_range(0, 12) : 0;
    seen = xfer_count;
    if (gap > 0) begin
      // Drop start and wiggle the payload while idle.
      junk.cmd   = cmd_t'($urandom_range(0, 3));
      junk.value = $urandom;
      start   <= 1'b0;
      in_data <= junk;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= '{cmd: c, value: v};
    do @(negedge clk); while (xfer_count == seen);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic refresh_pool();
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 5))
        0:       value_pool[k] = 32'h8000_0000;
        1:       value_pool[k] = 32'h7FFF_FFFF;
        2:       value_pool[k] = 32'hFFFF_FFFF;
        3:       value_pool[k] = 32'h0000_0000;
        default: value_pool[k] = $urandom;
      endcase
    end
  endtask

  initial begin
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] tail_value;
    cmd_t               c;
    int                 r;
    bit                 grow;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    pace_on = 1'b1;
    grow    = 1'b0;
    refresh_pool();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, fill to capacity with extremes and repeats,
    // refused append, hit and miss searches, multi-match delete, clear.
    drive_cmd(CMD_SEARCH, 32'h0000_0000);
    drive_cmd(CMD_DELETE, 32'h0000_0000);
    for (int i = 0; i < CAPACITY; i++) begin
      case (i)
        0, 4, 8, 12: v = 32'h8000_0000;
        1:           v = 32'h7FFF_FFFF;
        2:           v = 32'h0000_0000;
        3:           v = 32'hFFFF_FFFF;
        default:     v = $urandom;
      endcase
      drive_cmd(CMD_APPEND, v);
    end
    tail_value = v;
    drive_cmd(CMD_APPEND, 32'h1357_9BDF);
    drive_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
    drive_cmd(CMD_SEARCH, 32'h1357_9BDF);
    drive_cmd(CMD_DELETE, 32'h8000_0000);
    drive_cmd(CMD_DELETE, tail_value);
    drive_cmd(CMD_CLEAR, $urandom);
    drive_cmd(CMD_SEARCH, 32'hFFFF_FFFF);
    drain_results();

    // Random: bursts that either grow the list toward full or churn it,
    // with values mostly drawn from a small pool so searches and deletes hit.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 20 == 0) begin
        grow    = ($urandom_range(0, 2) == 0);
        pace_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) refresh_pool();
      end
      if (n % 150 == 75) drain_results();
      r = $urandom_range(0, 99);
      if (grow)
        c = (r < 70) ? CMD_APPEND : (r < 85) ? CMD_SEARCH : (r < 97) ? CMD_DELETE : CMD_CLEAR;
      else
        c = (r < 40) ? CMD_APPEND : (r < 70) ? CMD_SEARCH : (r < 92) ? CMD_DELETE : CMD_CLEAR;
      v = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 5)] : $urandom;
      drive_cmd(c, v);
    end

    // Let the last result land, then give the block time to show any stray strobe.
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_total == 0 && results_pending == 0) begin
      $display("[ordered_value_list_core] OK");
    end else begin
      $display("[ordered_value_list_core] ERROR");
    end
    $finish;
  end

endmodule
